### hdl/float_tolerance_compare_stream_assert.svh
// Assertion macros for the tolerance compare stream block.
`ifndef FLOAT_TOLERANCE_COMPARE_STREAM_ASSERT_SVH
`define FLOAT_TOLERANCE_COMPARE_STREAM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FTCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FTCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ftcs_pkg.sv
// Shared types, constants and helper functions for the tolerance compare stream.
`default_nettype none

package ftcs_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] REG_ABS_TOL = 8'd0;
    localparam logic [7:0] REG_REL_TOL = 8'd1;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [62:0] INF_MAG      = {11'h7FF, 52'd0};
    localparam logic [62:0] QNAN_MAG     = {11'h7FF, 1'b1, 51'd0};

    // classified pair, front to back
    typedef struct packed {
        logic [52:0] x_mant;   // larger magnitude operand
        logic [10:0] x_exp;
        logic [52:0] y_mant;   // smaller magnitude operand
        logic [10:0] y_exp;
        logic        eff_sub;
        logic        diff_nan;
        logic        diff_inf;
        logic [62:0] scale;    // max(|a|,|b|) under IEEE compare rules
        logic        last;
    } item_t;

    function automatic logic is_nan(input logic [62:0] mag);
        is_nan = (mag[62:52] == EXP_ALL_ONES) && (mag[51:0] != 52'd0);
    endfunction

    function automatic logic [52:0] eff_mant(input logic [62:0] mag);
        eff_mant = {mag[62:52] != 11'd0, mag[51:0]};
    endfunction

    function automatic logic [10:0] eff_exp(input logic [62:0] mag);
        eff_exp = (mag[62:52] == 11'd0) ? 11'd1 : mag[62:52];
    endfunction

    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] cnt;
        cnt = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (v[i]) begin
                cnt = 6'(55 - i);
            end
        end
        lzc56 = cnt;
    endfunction

    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] cnt;
        cnt = 7'd106;
        for (int i = 0; i < 106; i++) begin
            if (v[i]) begin
                cnt = 7'(105 - i);
            end
        end
        lzc106 = cnt;
    endfunction

    // IEEE "d > t" for a non-negative d
    function automatic logic gt_pos(input logic [62:0] d_mag, input logic d_nan,
                                    input logic [63:0] t);
        logic res;
        if (d_nan || is_nan(t[62:0])) begin
            res = 1'b0;
        end else if (t[63]) begin
            res = (d_mag != 63'd0) || (t[62:0] != 63'd0);
        end else begin
            res = d_mag > t[62:0];
        end
        gt_pos = res;
    endfunction

endpackage

`default_nettype wire

### hdl/float_tolerance_compare_stream.sv
// Top level: approximate equality of streamed IEEE double pairs with tolerances.
//
// Input stream s_*: one pair of doubles per transfer, s_tlast on the final
// pair of a vector. Result stream m_*: one transfer per vector, carrying
// all_match in m_tdata[0]; set when every pair of the vector matched.
// Config port cfg_*: index 0 absolute tolerance, index 1 relative tolerance,
// both double bit patterns; other indexes are dropped. cfg_ready is always high.
// Path from the last pair's input transfer to m_tvalid: front register, one
// queue slot, eight arithmetic stages, output register.
// Throughput: one pair per cycle unless a held result stalls the back end, set
// by the pipelined subtract and the four-part 53x53 multiply in the back end.
// Reset: pipeline and queue empty, tolerances +0.0, match flag armed.
// When a result waits and m_tready is low the back end holds; the queue keeps
// taking pairs until it and the front register fill, then s_tready drops.
`default_nettype none

module float_tolerance_compare_stream
    import ftcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // value_a [63:0], value_b [127:64]
    input  wire logic          s_tlast,   // last_element
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,   // all_match [0], zero [7:1]
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);

    logic [63:0] abs_tol_reg, rel_tol_reg;
    logic        push, q_full, q_empty, pop, out_match;
    item_t       f_item, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_tol_reg <= 64'd0;
            rel_tol_reg <= 64'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ABS_TOL: abs_tol_reg <= cfg_data;
                REG_REL_TOL: rel_tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ftcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_a     (s_tdata[63:0]),
        .in_b     (s_tdata[127:64]),
        .in_last  (s_tlast),
        .push     (push),
        .q_full   (q_full),
        .item     (f_item)
    );

    ftcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    ftcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .abs_tol   (abs_tol_reg),
        .rel_tol   (rel_tol_reg),
        .q_empty   (q_empty),
        .pop       (pop),
        .head      (q_head),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_match (out_match)
    );

    assign m_tdata = {7'd0, out_match};

endmodule

`default_nettype wire

### hdl/ftcs_front.sv
// Front end: accepts pairs, classifies operands and specials, pushes to the queue.
`default_nettype none

module ftcs_front
    import ftcs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [63:0]  in_a,
    input  wire logic [63:0]  in_b,
    input  wire logic         in_last,
    output logic              push,
    input  wire logic         q_full,
    output item_t             item
);

    logic  f_valid_reg;
    item_t f_item_reg;
    item_t item_next;

    logic [62:0] a_mag, b_mag, x_mag, y_mag;
    logic        a_nan, b_nan, a_inf, b_inf, swap, eff_sub;

    always_comb begin
        a_mag   = in_a[62:0];
        b_mag   = in_b[62:0];
        a_nan   = is_nan(a_mag);
        b_nan   = is_nan(b_mag);
        a_inf   = (a_mag == INF_MAG);
        b_inf   = (b_mag == INF_MAG);
        eff_sub = (in_a[63] == in_b[63]);
        swap    = b_mag > a_mag;
        x_mag   = swap ? b_mag : a_mag;
        y_mag   = swap ? a_mag : b_mag;

        item_next.x_mant   = eff_mant(x_mag);
        item_next.x_exp    = eff_exp(x_mag);
        item_next.y_mant   = eff_mant(y_mag);
        item_next.y_exp    = eff_exp(y_mag);
        item_next.eff_sub  = eff_sub;
        item_next.diff_nan = a_nan || b_nan || (a_inf && b_inf && eff_sub);
        item_next.diff_inf = a_inf || b_inf;
        // a NaN anywhere makes "|a| < |b|" false, so the scale is |a|
        item_next.scale    = (a_nan || b_nan) ? a_mag : x_mag;
        item_next.last     = in_last;
    end

    assign push     = f_valid_reg && !q_full;
    assign in_ready = !f_valid_reg || !q_full;
    assign item     = f_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (in_ready) begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            f_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ftcs_queue.sv
// Short queue between the classifying front end and the arithmetic back end.
`default_nettype none

module ftcs_queue
    import ftcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t         slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hdl/ftcs_back.sv
// Back end: pipelined double subtract, scale multiply, tolerance compares, sticky flag.
`default_nettype none

module ftcs_back
    import ftcs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [63:0]  abs_tol,
    input  wire logic [63:0]  rel_tol,
    input  wire logic         q_empty,
    output logic              pop,
    input  wire item_t        head,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              out_match
);

    logic adv;
    logic [8:1] vld_reg, last_reg, dnan_reg;
    logic [4:1] dinf_reg;
    logic [7:1] pnan_reg, pinf_reg, pzero_reg;
    logic       out_valid_reg, out_match_reg, sticky_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_match = out_match_reg;

    // ---------------- stage 1: align, partial products, specials
    logic [10:0]  d_shift;
    logic [55:0]  y_ext, y_sh, yal_next;
    logic         y_lost;
    logic [52:0]  ms, mt;
    logic [10:0]  es, et;
    logic         s_nan, t_nan, s_inf, t_inf, s_zero, t_zero;
    logic         pnan_next, pinf_next, pzero_next;

    always_comb begin
        d_shift  = head.x_exp - head.y_exp;
        y_ext    = {head.y_mant, 3'b000};
        y_sh     = y_ext >> d_shift;
        y_lost   = |(y_ext & ~({56{1'b1}} << d_shift));
        yal_next = {y_sh[55:1], y_sh[0] | y_lost};

        ms     = eff_mant(head.scale);
        es     = eff_exp(head.scale);
        mt     = eff_mant(rel_tol[62:0]);
        et     = eff_exp(rel_tol[62:0]);
        s_nan  = is_nan(head.scale);
        t_nan  = is_nan(rel_tol[62:0]);
        s_inf  = (head.scale == INF_MAG);
        t_inf  = (rel_tol[62:0] == INF_MAG);
        s_zero = (head.scale == 63'd0);
        t_zero = (rel_tol[62:0] == 63'd0);
        pnan_next  = s_nan || t_nan || (s_inf && t_zero) || (t_inf && s_zero);
        pinf_next  = !pnan_next && (s_inf || t_inf);
        pzero_next = !pnan_next && !pinf_next && (s_zero || t_zero);
    end

    logic [55:0]  s1_xw_reg, s1_yal_reg;
    logic [11:0]  s1_er_reg, s1_esum_reg;
    logic         s1_sub_reg;
    logic [53:0]  s1_p00_reg;
    logic [52:0]  s1_p01_reg, s1_p10_reg;
    logic [51:0]  s1_p11_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_xw_reg   <= {head.x_mant, 3'b000};
            s1_yal_reg  <= yal_next;
            s1_er_reg   <= {1'b0, head.x_exp};
            s1_sub_reg  <= head.eff_sub;
            s1_esum_reg <= {1'b0, es} + {1'b0, et};
            s1_p00_reg  <= ms[26:0] * mt[26:0];
            s1_p01_reg  <= ms[26:0] * mt[52:27];
            s1_p10_reg  <= ms[52:27] * mt[26:0];
            s1_p11_reg  <= ms[52:27] * mt[52:27];
        end
    end

    // ---------------- stage 2: add or subtract magnitudes, sum middle products
    logic [56:0]  s2_sum_reg;
    logic [11:0]  s2_er_reg, s2_esum_reg;
    logic         s2_sub_reg;
    logic [53:0]  s2_mid_reg, s2_p00_reg;
    logic [51:0]  s2_p11_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_sum_reg  <= s1_sub_reg ? ({1'b0, s1_xw_reg} - {1'b0, s1_yal_reg})
                                      : ({1'b0, s1_xw_reg} + {1'b0, s1_yal_reg});
            s2_er_reg   <= s1_er_reg;
            s2_sub_reg  <= s1_sub_reg;
            s2_esum_reg <= s1_esum_reg;
            s2_mid_reg  <= {1'b0, s1_p01_reg} + {1'b0, s1_p10_reg};
            s2_p00_reg  <= s1_p00_reg;
            s2_p11_reg  <= s1_p11_reg;
        end
    end

    // ---------------- stage 3: carry fixup and leading zeros, full product
    logic [55:0] w_next;
    logic [11:0] er3_next;

    always_comb begin
        if (!s2_sub_reg && s2_sum_reg[56]) begin
            w_next   = {s2_sum_reg[56:2], s2_sum_reg[1] | s2_sum_reg[0]};
            er3_next = s2_er_reg + 12'd1;
        end else begin
            w_next   = s2_sum_reg[55:0];
            er3_next = s2_er_reg;
        end
    end

    logic [55:0]  s3_w_reg;
    logic [11:0]  s3_er_reg, s3_esum_reg;
    logic [5:0]   s3_lz_reg;
    logic [105:0] s3_prod_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_w_reg    <= w_next;
            s3_er_reg   <= er3_next;
            s3_lz_reg   <= lzc56(w_next);
            s3_esum_reg <= s2_esum_reg;
            s3_prod_reg <= {s2_p11_reg, s2_p00_reg} + {25'd0, s2_mid_reg, 27'd0};
        end
    end

    // ---------------- stage 4: normalize difference, product leading zeros
    logic [11:0] lim, nsh;

    always_comb begin
        lim = s3_er_reg - 12'd1;
        nsh = ({6'd0, s3_lz_reg} < lim) ? {6'd0, s3_lz_reg} : lim;
    end

    logic [55:0]  s4_w_reg;
    logic [11:0]  s4_er_reg, s4_esum_reg;
    logic [105:0] s4_prod_reg;
    logic [6:0]   s4_plz_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_w_reg    <= s3_w_reg << nsh;
            s4_er_reg   <= s3_er_reg - nsh;
            s4_esum_reg <= s3_esum_reg;
            s4_prod_reg <= s3_prod_reg;
            s4_plz_reg  <= lzc106(s3_prod_reg);
        end
    end

    // ---------------- stage 5: round difference, normalize product
    logic        d_inc;
    logic [10:0] d_expf;
    logic [62:0] d_packed, dmag_next;

    always_comb begin
        d_expf    = s4_w_reg[55] ? s4_er_reg[10:0] : 11'd0;
        d_inc     = s4_w_reg[2] & (s4_w_reg[1] | s4_w_reg[0] | s4_w_reg[3]);
        d_packed  = {d_expf, s4_w_reg[54:3]} + {62'd0, d_inc};
        dmag_next = (dinf_reg[4] || s4_er_reg >= 12'd2047) ? INF_MAG : d_packed;
    end

    logic [62:0]  dmag_reg [5:8];
    logic [105:0] s5_pn_reg;
    logic [12:0]  s5_pe_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_pn_reg   <= s4_prod_reg << s4_plz_reg;
            s5_pe_reg   <= {1'b0, s4_esum_reg} - {6'd0, s4_plz_reg} - 13'd1022;
        end
    end

    // ---------------- stage 6: denormalize product below the normal range
    logic [12:0]  rs_full;
    logic [6:0]   rs;
    logic [105:0] pr_sh;
    logic         pr_lost, under;

    always_comb begin
        under   = s5_pe_reg[12] || (s5_pe_reg == 13'd0);
        rs_full = 13'd1 - s5_pe_reg;
        rs      = (rs_full > 13'd127) ? 7'd127 : rs_full[6:0];
        pr_sh   = s5_pn_reg >> rs;
        pr_lost = |(s5_pn_reg & ~({106{1'b1}} << rs));
    end

    logic [105:0] s6_pr_reg;
    logic [11:0]  s6_pe_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_pr_reg <= under ? {pr_sh[105:1], pr_sh[0] | pr_lost} : s5_pn_reg;
            s6_pe_reg <= under ? 12'd1 : s5_pe_reg[11:0];
        end
    end

    // ---------------- stage 7: round product into the bound
    logic [105:0] s7_pr_reg;
    logic [11:0]  s7_pe_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_pr_reg <= s6_pr_reg;
            s7_pe_reg <= s6_pe_reg;
        end
    end

    logic        p_inc;
    logic [10:0] p_expf;
    logic [62:0] p_packed, bmag_next;

    always_comb begin
        p_expf   = s7_pr_reg[105] ? s7_pe_reg[10:0] : 11'd0;
        p_inc    = s7_pr_reg[52] & ((|s7_pr_reg[51:0]) | s7_pr_reg[53]);
        p_packed = {p_expf, s7_pr_reg[104:53]} + {62'd0, p_inc};
        if (pnan_reg[7]) begin
            bmag_next = QNAN_MAG;
        end else if (pinf_reg[7] || s7_pe_reg >= 12'd2047) begin
            bmag_next = INF_MAG;
        end else if (pzero_reg[7]) begin
            bmag_next = 63'd0;
        end else begin
            bmag_next = p_packed;
        end
    end

    logic [63:0] s8_bound_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_bound_reg <= {rel_tol[63], bmag_next};
        end
    end

    // carried flags and difference
    always_ff @(posedge aclk) begin
        if (adv) begin
            dnan_reg[1]  <= head.diff_nan;
            dinf_reg[1]  <= head.diff_inf;
            last_reg[1]  <= head.last;
            pnan_reg[1]  <= pnan_next;
            pinf_reg[1]  <= pinf_next;
            pzero_reg[1] <= pzero_next;
            dmag_reg[5]  <= dmag_next;
            for (int i = 2; i <= 8; i++) begin
                last_reg[i] <= last_reg[i-1];
                dnan_reg[i] <= dnan_reg[i-1];
            end
            for (int i = 2; i <= 4; i++) begin
                dinf_reg[i] <= dinf_reg[i-1];
            end
            for (int i = 2; i <= 7; i++) begin
                pnan_reg[i]  <= pnan_reg[i-1];
                pinf_reg[i]  <= pinf_reg[i-1];
                pzero_reg[i] <= pzero_reg[i-1];
            end
            for (int i = 6; i <= 8; i++) begin
                dmag_reg[i] <= dmag_reg[i-1];
            end
        end
    end

    // ---------------- retire: compares, sticky flag, result register
    logic pair_ok;

    assign pair_ok = !gt_pos(dmag_reg[8], dnan_reg[8], abs_tol)
                  || !gt_pos(dmag_reg[8], dnan_reg[8], s8_bound_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            sticky_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[7:1], !q_empty};
            if (vld_reg[8]) begin
                sticky_reg    <= last_reg[8] ? 1'b1 : (sticky_reg && pair_ok);
                out_valid_reg <= last_reg[8];
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[8] && last_reg[8]) begin
            out_match_reg <= sticky_reg && pair_ok;
        end
    end

endmodule

`default_nettype wire

### hdl/ftcs_checker.sv
// Port-level checker for the tolerance compare stream, bound to the top level.
`default_nettype none

`include "float_tolerance_compare_stream_assert.svh"

module ftcs_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [7:0]    m_tdata
);

    `FTCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `FTCS_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0, "result padding bits not zero")
    `FTCS_ASSERT_NOW(a_rst_out, aclk, aresetn, !$past(aresetn), !m_tvalid, "result valid right after reset")
    `FTCS_ASSERT_NOW(a_rst_in, aclk, aresetn, !$past(aresetn), s_tready, "input not ready right after reset")

endmodule

bind float_tolerance_compare_stream ftcs_checker u_ftcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the streamed double-pair tolerance compare block.
`default_nettype none

module testbench;
    import ftcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SIGN_OFF  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  REG_SPARE = 8'd2;
    localparam logic [7:0]  REG_TOP   = 8'hFF;
    localparam int          DRAIN_CYCLES = 30;

    // Tracks the sticky all-match flag and the verdicts owed by the block.
    class vector_match_board;
        logic [63:0] abs_tol;
        logic [63:0] rel_tol;
        bit          match_so_far;
        bit          expected_verdicts[$];
        int          errors;
        int          reported;

        function new();
            abs_tol = 64'd0;
            rel_tol = 64'd0;
            match_so_far = 1'b1;
            errors = 0;
            reported = 0;
        endfunction

        function void set_register(logic [7:0] idx, logic [63:0] val);
            if (idx == REG_ABS_TOL) begin
                abs_tol = val;
            end else if (idx == REG_REL_TOL) begin
                rel_tol = val;
            end
        endfunction

        function bit pair_within(logic [63:0] a, logic [63:0] b);
            real ra, rb, diff, ma, mb, scale, bound;
            ra = $bitstoreal(a);
            rb = $bitstoreal(b);
            diff = $bitstoreal($realtobits(ra - rb) & SIGN_OFF);
            if (!(diff > $bitstoreal(abs_tol))) begin
                return 1'b1;
            end
            ma = $bitstoreal(a & SIGN_OFF);
            mb = $bitstoreal(b & SIGN_OFF);
            scale = (ma < mb) ? mb : ma;
            bound = scale * $bitstoreal(rel_tol);
            return !(diff > bound);
        endfunction

        function void note_pair(logic [63:0] a, logic [63:0] b, bit last);
            match_so_far = match_so_far & pair_within(a, b);
            if (last) begin
                expected_verdicts.push_back(match_so_far);
                match_so_far = 1'b1;
            end
        endfunction

        function void fail(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("%0t: %s expected %h got %h", $realtime, what, want, got);
            end
        endfunction

        function void check_verdict(logic [7:0] tdata);
            bit want;
            if (expected_verdicts.size() == 0) begin
                fail("unexpected result transfer", 8'h00, tdata);
                return;
            end
            want = expected_verdicts.pop_front();
            if (tdata !== {7'd0, want}) begin
                fail("all_match", {7'd0, want}, tdata);
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;   // value_a [63:0], value_b [127:64]
    logic          s_tlast;   // last_element
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;   // all_match [0], zero [7:1]
    logic          cfg_valid;
    logic          cfg_ready;
    logic [7:0]    cfg_index;
    logic [63:0]   cfg_data;

    vector_match_board board;
    bit quiet;

    float_tolerance_compare_stream DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stall bursts, always ready once quiet
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_verdict(m_tdata);
        end
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_register(logic [7:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(logic [63:0] a, logic [63:0] b, bit last);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_pair(a, b, last);
    endtask

    // block drained: all verdicts in, plus pipeline depth with no tail in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (board.expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] special_value();
        case ($urandom_range(0, 9))
            0: return 64'h0000_0000_0000_0000;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FF0_0000_0000_0000;
            3: return 64'hFFF0_0000_0000_0000;
            4: return 64'h7FF8_0000_0000_0000;
            5: return {1'b1, 11'h7FF, 1'b0, 51'($urandom) | 51'd1};
            6: return 64'h7FEF_FFFF_FFFF_FFFF;
            7: return 64'h0000_0000_0000_0001;
            8: return {$urandom_range(0, 1) == 1, 11'd0, 52'(rand_bits())};
            default: return 64'h3FF0_0000_0000_0000;
        endcase
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return special_value();
            1: return rand_bits();
            default: return {1'($urandom), 11'($urandom_range(1000, 1046)), 52'(rand_bits())};
        endcase
    endfunction

    // partner value: mostly close to a so that tolerances decide
    function automatic logic [63:0] partner_of(logic [63:0] a);
        int nb;
        nb = $urandom_range(1, 52);
        case ($urandom_range(0, 6))
            0: return a;
            1: return a ^ 64'h8000_0000_0000_0000;
            2: return rand_value();
            default: return a ^ (rand_bits() & ((64'd1 << nb) - 64'd1));
        endcase
    endfunction

    task automatic random_vectors(int count);
        int len;
        logic [63:0] a;
        while (count > 0) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                a = rand_value();
                send_pair(a, partner_of(a), i == len - 1);
            end
            count -= len;
        end
    endtask

    logic [63:0] dir_a[$];
    logic [63:0] dir_b[$];
    logic [63:0] tol_abs_set[$];
    logic [63:0] tol_rel_set[$];
    int wait_cycles;

    initial begin
        board = new();
        quiet = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pairs under reset tolerances (+0.0), each its own vector
        dir_a = '{64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                  64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000,
                  64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000};
        dir_b = '{64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                  64'h3FF0_0000_0000_0000, 64'hFFF8_0000_0000_0001, 64'h8000_0000_0000_0000,
                  64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0002, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h3FF0_0000_0000_0001, 64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF};
        foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i], 1'b1);
        // one mismatch inside a longer vector must clear the whole verdict
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0);
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1);
        settle();

        tol_abs_set = '{$realtobits(1.0e-9), rand_bits(), $realtobits(-1.0),
                        64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                        $realtobits(1.0e-12)};
        tol_rel_set = '{$realtobits(1.0e-6), rand_bits(), 64'h7FF8_0000_0000_0000,
                        $realtobits(-0.5), 64'h0000_0000_0000_0000,
                        64'h7FEF_FFFF_FFFF_FFFF, $realtobits(0.5),
                        $realtobits(1.0e-15)};
        foreach (tol_abs_set[p]) begin
            write_register(REG_ABS_TOL, tol_abs_set[p]);
            write_register(REG_REL_TOL, tol_rel_set[p]);
            // writes to unused indexes must leave the tolerances alone
            write_register(($urandom_range(0, 1) == 1) ? REG_TOP : REG_SPARE, rand_bits());
            if (p == tol_abs_set.size() - 1) begin
                quiet = 1'b1;
            end
            random_vectors(55);
            settle();
        end

        wait_cycles = 0;
        while (board.expected_verdicts.size() != 0 && wait_cycles < 2000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
